### rtl/skt_pkg.sv
// Shared types and constants for the sorted key table search block.
package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int KEY_W           = 32;
    localparam int ENTRY_IDX_W     = 12;
    localparam int COUNT_W         = 13;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMPTY
    } search_state_t;

endpackage

### rtl/skt_mem.sv
// Key and valid-bit table: one write port, one read port with registered data.
module skt_mem #(
    parameter  int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  skt_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output skt_pkg::entry_t      rd_data
);
    import skt_pkg::*;

    entry_t mem_array [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/skt_search.sv
// Request sequencer: table loads, binary search probes and the result register.
module skt_search #(
    parameter  int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [skt_pkg::ENTRY_IDX_W-1:0] entry_index,
    input  logic [skt_pkg::KEY_W-1:0]       key_value,
    input  logic                            entry_valid,
    input  logic [skt_pkg::COUNT_W-1:0]     entry_count,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [skt_pkg::ENTRY_IDX_W-1:0] match_index,
    output logic                            mem_wr_en,
    output logic [IDX_W-1:0]                mem_wr_addr,
    output skt_pkg::entry_t                 mem_wr_data,
    output logic                            mem_rd_en,
    output logic [IDX_W-1:0]                mem_rd_addr,
    input  skt_pkg::entry_t                 mem_rd_data
);
    import skt_pkg::*;

    search_state_t          state_reg, state_next;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    logic [IDX_W-1:0]       mid_reg, mid_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [ENTRY_IDX_W-1:0] idx_reg, idx_next;

    logic                   accept;
    logic                   out_free;
    logic [CNT_W-1:0]       hi_init;
    logic                   rd_match;
    logic                   last_probe;
    logic                   go_up;
    logic [CNT_W-1:0]       mid_ext;
    logic [CNT_W-1:0]       lo_step;
    logic [CNT_W-1:0]       hi_step;
    logic [CNT_W-1:0]       mid_step;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // clamp the searched range to the table
    always_comb
    begin
        if (32'(entry_count) > 32'(TABLE_DEPTH))
        begin
            hi_init = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            hi_init = CNT_W'(entry_count);
        end
    end

    // loads write straight through; drop slots beyond the table
    assign mem_wr_en         = accept && (operation == OP_LOAD)
                               && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign mem_wr_addr       = IDX_W'(entry_index);
    assign mem_wr_data.key   = key_value;
    assign mem_wr_data.valid = entry_valid;

    // read data belongs to the probe at mid_reg
    assign rd_match   = mem_rd_data.valid && (mem_rd_data.key == key_reg);
    assign last_probe = (hi_reg == lo_reg + CNT_W'(1));
    assign go_up      = (key_reg >= mem_rd_data.key);
    assign mid_ext    = CNT_W'(mid_reg);
    assign lo_step    = go_up ? mid_ext : lo_reg;
    assign hi_step    = go_up ? hi_reg : mid_ext;
    assign mid_step   = lo_step + ((hi_step - lo_step) >> 1);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        idx_next       = idx_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = mid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_LOOKUP))
                begin
                    key_next = key_value;
                    if (hi_init == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        lo_next     = '0;
                        hi_next     = hi_init;
                        mid_next    = IDX_W'(hi_init >> 1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(hi_init >> 1);
                        state_next  = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (rd_match || last_probe)
                begin
                    // finish only once the result register is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = rd_match;
                        idx_next       = rd_match ? ENTRY_IDX_W'(mid_reg) : '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    lo_next     = lo_step;
                    hi_next     = hi_step;
                    mid_next    = IDX_W'(mid_step);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(mid_step);
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    idx_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        idx_reg   <= idx_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = idx_reg;

endmodule

### rtl/sorted_key_table_binary_search.sv
// Sorted key table with binary search lookup.
//
// Input channel (in_valid / in_stall) carries one request per handshake:
// operation selects a load, which writes key_value and entry_valid into slot
// entry_index, or a lookup, which searches the first entry_count slots for
// key_value. Slots at or beyond TABLE_DEPTH are not written.
// A load writes its slot as it is accepted and gives no result. A lookup
// probes the table memory once per cycle, one read each, until a probe
// matches or its range narrows to one slot; an empty range goes through
// ST_EMPTY and gives its result without reading the table.
// Requests are handled one at a time; in_stall is high while a lookup runs.
// Output channel (out_valid / out_stall) carries found and match_index, which
// is zero when nothing matches. While the receiver stalls, the result holds
// and a finishing lookup waits for the result register to drain.
// The user must write entry_count (cfg_wr_en / cfg_wr_data) only while idle;
// the block does not enforce this. Reset clears entry_count and the control
// state; table contents are undefined until loaded, and only loaded slots may be searched.
module sorted_key_table_binary_search #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [skt_pkg::ENTRY_IDX_W-1:0] entry_index,
    input  logic [skt_pkg::KEY_W-1:0]       key_value,
    input  logic                            entry_valid,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [skt_pkg::ENTRY_IDX_W-1:0] match_index,
    input  logic                            cfg_wr_en,
    input  logic [skt_pkg::COUNT_W-1:0]     cfg_wr_data
);
    import skt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0] entry_count_reg;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    entry_t             mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    entry_t             mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    skt_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .entry_index (entry_index),
        .key_value   (key_value),
        .entry_valid (entry_valid),
        .entry_count (entry_count_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    skt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    a_miss_index_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_index == '0)
    ) else $error("miss result carries a nonzero index");

    a_hit_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> ({1'b0, match_index} < entry_count_reg)
    ) else $error("hit index outside the searched range");

    a_result_from_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared with no lookup in progress");

    a_lookup_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == OP_LOOKUP)) |=> in_stall
    ) else $error("accepted lookup did not occupy the search");

endmodule
